### rtl/gbe_pkg.sv
// Shared types, widths and helpers for the Golomb byte encoder.
// No dependencies; every RTL file imports this package.
`default_nettype none

package gbe_pkg;

  // Field widths
  localparam int SYM_W   = 8;   // input byte
  localparam int DIV_W   = 9;   // divisor register
  localparam int BLEN_W  = 4;   // bit length of the divisor, 1..9
  localparam int LEN_W   = 9;   // code length, up to 256 bits
  localparam int CODE_W  = 10;  // marker one plus up to nine remainder bits
  localparam int BITS_W  = 32;  // chunk_bits port
  localparam int BCNT_W  = 6;   // bit_count port

  // Divider pipeline shape: SYM_W quotient bits, STEP_BITS per stage
  localparam int STEP_BITS  = 2;
  localparam int DIV_STAGES = SYM_W / STEP_BITS;

  // Defaults for the top-level parameters
  localparam int CHUNK_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(4);

  // One classified symbol waiting for the back end
  typedef struct packed {
    logic [LEN_W-1:0]  len;   // total code length in bits
    logic [CODE_W-1:0] code;  // marker one followed by the remainder bits
    logic              fin;   // last symbol of the block
  } gbe_entry_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [DIV_W:0] div_step(input logic [DIV_W-1:0] rem,
                                              input logic             din,
                                              input logic [DIV_W-1:0] m);
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, m};
    if (trial >= {1'b0, m}) begin
      div_step = {1'b1, diff[DIV_W-1:0]};
    end else begin
      div_step = {1'b0, trial[DIV_W-1:0]};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/golomb_byte_encoder.sv
// Top level of the Golomb byte encoder: divisor register, credit counter,
// front end, symbol queue and back end. Depends on gbe_pkg.
//
// Usage:
//   Write the Golomb parameter m with divisor_we_i / divisor_i while idle
//   (zero acts as one). Present a byte on symbol_i with final_symbol_i and
//   raise start_i; the byte is taken at an edge where busy_o is low.
//   Each symbol's code (q zeros, a one, truncated-binary remainder) leaves
//   as one or more chunks of up to CHUNK_WIDTH bits, right aligned, each
//   shown for one cycle with chunk_valid_o; chunk_last_o marks the last
//   chunk of a symbol and block_end_o that of the final symbol.
// Path of a byte: divider stages, classifier register, queue, output flop.
// Throughput: one byte per cycle while every code fits in one chunk; a
//   code of several chunks keeps the back end until its last chunk, and
//   the byte stream stalls through busy_o once QUEUE_DEPTH symbols are in
//   flight. The four-stage divider and the classifier run at one byte per cycle.
// Reset: divisor returns to 4, the queue and all pipelines empty.
// The receiver cannot stall: chunks are produced without back-pressure.
`default_nettype none

module golomb_byte_encoder
  import gbe_pkg::*;
#(
  parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic              final_symbol_i,
  input  wire logic              divisor_we_i,
  input  wire logic [DIV_W-1:0]  divisor_i,
  output logic                   chunk_valid_o,
  output logic [BITS_W-1:0]      chunk_bits_o,
  output logic [BCNT_W-1:0]      bit_count_o,
  output logic                   chunk_last_o,
  output logic                   block_end_o
);

  localparam int CRED_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CRED_W-1:0] CRED_MAX = CRED_W'(QUEUE_DEPTH);

  logic [DIV_W-1:0]  divisor_q;
  logic [CRED_W-1:0] inflight_q, inflight_d;
  logic              accept;
  logic              push;
  logic              pop;
  logic              empty;
  gbe_entry_t        entry;
  gbe_entry_t        head;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= DIVISOR_RESET;
    end else if (divisor_we_i) begin
      divisor_q <= divisor_i;
    end
  end

  // Count symbols from accept until they leave the queue
  assign accept = start_i && !busy_o;
  assign busy_o = (inflight_q == CRED_MAX);

  always_comb begin
    case ({accept, pop})
      2'b10:   inflight_d = inflight_q + CRED_W'(1);
      2'b01:   inflight_d = inflight_q - CRED_W'(1);
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  gbe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .symbol_i       (symbol_i),
    .final_symbol_i (final_symbol_i),
    .divisor_i      (divisor_q),
    .push_o         (push),
    .entry_o        (entry)
  );

  gbe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  gbe_back #(
    .CHUNK_WIDTH (CHUNK_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .chunk_valid_o (chunk_valid_o),
    .chunk_bits_o  (chunk_bits_o),
    .bit_count_o   (bit_count_o),
    .chunk_last_o  (chunk_last_o),
    .block_end_o   (block_end_o)
  );

endmodule

`default_nettype wire

### rtl/gbe_front.sv
// Front end: pipelined restoring divider and truncated-binary classifier.
// Depends on gbe_pkg; feeds gbe_fifo with one gbe_entry_t per symbol.
`default_nettype none

module gbe_front
  import gbe_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [SYM_W-1:0] symbol_i,
  input  wire logic             final_symbol_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  push_o,
  output gbe_entry_t            entry_o
);

  // Effective divisor: zero acts as one
  logic [DIV_W-1:0]  m;
  logic [BLEN_W-1:0] blen;
  logic [DIV_W:0]    u_full;
  logic [DIV_W-1:0]  u;

  assign m = (divisor_i == '0) ? DIV_W'(1) : divisor_i;

  // Bit length of the divisor
  always_comb begin
    blen = '0;
    for (int i = 0; i < DIV_W; i++) begin
      if (m[i]) begin
        blen = BLEN_W'(i + 1);
      end
    end
  end

  // Threshold u = 2^b - m
  assign u_full = ({{DIV_W{1'b0}}, 1'b1} << blen) - {1'b0, m};
  assign u      = u_full[DIV_W-1:0];

  // Divider stage registers
  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES-1:0] fin_q;
  logic [DIV_W-1:0]      rem_q [DIV_STAGES];
  logic [SYM_W-1:0]      quo_q [DIV_STAGES];
  logic [SYM_W-1:0]      dvd_q [DIV_STAGES];
  logic [DIV_W-1:0]      rem_d [DIV_STAGES];
  logic [SYM_W-1:0]      quo_d [DIV_STAGES];
  logic [SYM_W-1:0]      dvd_d [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [SYM_W-1:0] quo_in;
    logic [SYM_W-1:0] dvd_in;

    if (s == 0) begin : g_head
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = symbol_i;
    end else begin : g_body
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign dvd_in = dvd_q[s-1];
    end

    // Retire STEP_BITS quotient bits, dividend MSB first
    always_comb begin
      logic [DIV_W:0]   step;
      logic [DIV_W-1:0] rem;
      logic [SYM_W-1:0] quo;
      logic [SYM_W-1:0] dvd;
      rem = rem_in;
      quo = quo_in;
      dvd = dvd_in;
      for (int j = 0; j < STEP_BITS; j++) begin
        step = div_step(rem, dvd[SYM_W-1], m);
        quo  = {quo[SYM_W-2:0], step[DIV_W]};
        rem  = step[DIV_W-1:0];
        dvd  = {dvd[SYM_W-2:0], 1'b0};
      end
      rem_d[s] = rem;
      quo_d[s] = quo;
      dvd_d[s] = dvd;
    end
  end

  // Advance the divider pipeline every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DIV_STAGES-2:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= {fin_q[DIV_STAGES-2:0], final_symbol_i};
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
      dvd_q[s] <= dvd_d[s];
    end
  end

  // Classify the remainder into truncated binary
  logic [DIV_W-1:0]  r;
  logic              short_code;
  logic [BLEN_W-1:0] k;
  logic [DIV_W-1:0]  val;
  gbe_entry_t        entry_d;
  gbe_entry_t        entry_q;
  logic              push_q;

  assign r          = rem_q[DIV_STAGES-1];
  assign short_code = (r < u);
  assign k          = short_code ? (blen - BLEN_W'(1)) : blen;
  assign val        = short_code ? r : (r + u);

  always_comb begin
    entry_d.len  = LEN_W'(quo_q[DIV_STAGES-1]) + LEN_W'(1) + LEN_W'(k);
    entry_d.code = (CODE_W'(1) << k) | CODE_W'(val);
    entry_d.fin  = fin_q[DIV_STAGES-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
    end else begin
      push_q <= vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign push_o  = push_q;
  assign entry_o = entry_q;

endmodule

`default_nettype wire

### rtl/gbe_fifo.sv
// Short flop-based queue of classified symbols between front and back end.
// Depends on gbe_pkg for gbe_entry_t; overflow is prevented by the caller.
`default_nettype none

module gbe_fifo
  import gbe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire gbe_entry_t entry_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output gbe_entry_t      head_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  gbe_entry_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

### rtl/gbe_back.sv
// Back end: cuts the queued code word into chunks, one chunk per cycle.
// Depends on gbe_pkg; reads the head of gbe_fifo and drives the result ports.
`default_nettype none

module gbe_back
  import gbe_pkg::*;
#(
  parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       empty_i,
  input  wire gbe_entry_t head_i,
  output logic            pop_o,
  output logic            chunk_valid_o,
  output logic [BITS_W-1:0] chunk_bits_o,
  output logic [BCNT_W-1:0] bit_count_o,
  output logic            chunk_last_o,
  output logic            block_end_o
);

  localparam logic [LEN_W-1:0] CW_L   = LEN_W'(CHUNK_WIDTH);
  localparam logic [LEN_W-1:0] CODE_L = LEN_W'(CODE_W);

  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]  remaining;
  logic              last;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  shift;
  logic [CODE_W-1:0] shifted;
  logic [CODE_W-1:0] mask;
  logic [CODE_W-1:0] chunk;

  // Size the current chunk
  assign remaining = head_i.len - pos_q;
  assign last      = (remaining <= CW_L);
  assign cnt       = last ? remaining : CW_L;
  assign shift     = remaining - cnt;

  // Leading zeros of the unary part read as zero; only the tail holds ones
  assign shifted = (shift >= CODE_L) ? '0 : (head_i.code >> shift);
  assign mask    = (cnt >= CODE_L) ? '1 : ((CODE_W'(1) << cnt) - CODE_W'(1));
  assign chunk   = shifted & mask;

  assign pop_o = !empty_i && last;

  // Step through the code word
  always_comb begin
    pos_d = pos_q;
    if (!empty_i) begin
      pos_d = last ? '0 : (pos_q + CW_L);
    end
  end

  logic              valid_q;
  logic              last_q;
  logic              end_q;
  logic [BITS_W-1:0] bits_q;
  logic [BCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= !empty_i;
      last_q  <= !empty_i && last;
      end_q   <= !empty_i && last && head_i.fin;
    end
  end

  // Hold the chunk payload for its one-cycle strobe
  always_ff @(posedge clk_i) begin
    bits_q  <= {{(BITS_W-CODE_W){1'b0}}, chunk};
    count_q <= cnt[BCNT_W-1:0];
  end

  assign chunk_valid_o = valid_q;
  assign chunk_bits_o  = bits_q;
  assign bit_count_o   = count_q;
  assign chunk_last_o  = last_q;
  assign block_end_o   = end_q;

endmodule

`default_nettype wire

### rtl/gbe_checker.sv
// Port-level checks on the chunk stream of golomb_byte_encoder.
// Depends on gbe_pkg; attached to the top level by the bind below.
`default_nettype none

module gbe_checker
  import gbe_pkg::*;
#(
  parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              chunk_valid_o,
  input wire logic [BITS_W-1:0] chunk_bits_o,
  input wire logic [BCNT_W-1:0] bit_count_o,
  input wire logic              chunk_last_o,
  input wire logic              block_end_o
);

  // Block end only on the closing chunk of a symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_end_o |-> chunk_valid_o && chunk_last_o)
    else $error("block_end without a closing chunk");

  // No code bits above the counted ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_valid_o && bit_count_o != '0 && bit_count_o < BCNT_W'(BITS_W)
      |-> (chunk_bits_o >> bit_count_o) == '0)
    else $error("chunk bits set above bit_count");

  // Only the closing chunk may be partial
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_valid_o && !chunk_last_o |-> bit_count_o == BCNT_W'(CHUNK_WIDTH))
    else $error("partial chunk before the end of a code");

  // Chunks of one code come back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_valid_o && !chunk_last_o |=> chunk_valid_o)
    else $error("gap inside a code word");

endmodule

bind golomb_byte_encoder gbe_checker #(
  .CHUNK_WIDTH (CHUNK_WIDTH)
) u_gbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .chunk_valid_o (chunk_valid_o),
  .chunk_bits_o  (chunk_bits_o),
  .bit_count_o   (bit_count_o),
  .chunk_last_o  (chunk_last_o),
  .block_end_o   (block_end_o)
);

`default_nettype wire
